// ===== hdl/gnpe_pkg.sv =====
`timescale 1ns / 1ps
package gnpe_pkg;

  localparam int unsigned GRAD_W  = 32;
  localparam int unsigned FRAC_W  = 17;              // Q0.16 with room for 1.0
  localparam int unsigned DOT_W   = 36;              // Q.30 dot products and blends
  localparam int unsigned LERP_W  = DOT_W + FRAC_W + 2;
  localparam int unsigned DISP_W  = DOT_W + 10;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_CNT_W = 3;
  localparam int unsigned Q_PTR_W = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  // Corner order: bottom-left, bottom-right, top-left, top-right
  typedef struct packed {
    logic [3:0][GRAD_W-1:0] grad;
    logic [FRAC_W-1:0]      fx;
    logic [FRAC_W-1:0]      fy;
    logic [FRAC_W-1:0]      sx;
    logic [FRAC_W-1:0]      sy;
  } item_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               not_empty;
  } q_status_t;

  function automatic logic signed [DOT_W-1:0] corner_dot(
    input logic [GRAD_W-1:0]  word,
    input logic signed [17:0] dx,
    input logic signed [17:0] dy
  );
    logic signed [DOT_W-1:0] gx;
    logic signed [DOT_W-1:0] gy;
    gx = DOT_W'($signed(word[15:0]));
    gy = DOT_W'($signed(word[31:16]));
    return gx * DOT_W'(dx) + gy * DOT_W'(dy);
  endfunction

  // a + trunc((b - a) * s / 2^16), truncation toward zero
  function automatic logic signed [DOT_W-1:0] lerp(
    input logic signed [DOT_W-1:0] a,
    input logic signed [DOT_W-1:0] b,
    input logic [FRAC_W-1:0]       s
  );
    logic signed [DOT_W:0]    diff;
    logic signed [LERP_W-1:0] p;
    logic signed [LERP_W-1:0] q;
    diff = (DOT_W+1)'(b) - (DOT_W+1)'(a);
    p    = LERP_W'(diff) * LERP_W'($signed({1'b0, s}));
    if (p < 0) begin
      q = (p + LERP_W'(65535)) >>> 16;
    end else begin
      q = p >>> 16;
    end
    return a + DOT_W'(q);
  endfunction

endpackage

// ===== hdl/gnpe_front.sv =====
`timescale 1ns / 1ps
module gnpe_front #(
  parameter int unsigned CELLS_ACROSS    = 16,
  parameter int unsigned CELLS_DOWN      = 16,
  parameter int unsigned PIXELS_PER_CELL = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [55:0]        s_axis_tdata,  // cell_col, cell_row, grad_x, grad_y, offset_col, offset_row
  input  logic               s_axis_tuser,  // opcode
  input  gnpe_pkg::q_status_t q_status_i,
  output logic               q_push_o,
  output gnpe_pkg::item_t    q_item_o
);
  import gnpe_pkg::*;

  localparam int unsigned BANK_COLS  = (CELLS_ACROSS + 2) / 2;
  localparam int unsigned BANK_ROWS  = (CELLS_DOWN + 2) / 2;
  localparam int unsigned BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int unsigned AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [4:0]  cell_col, cell_row;
  logic [31:0] grad_word;
  logic [6:0]  off_col, off_row;
  logic        beat, is_load, is_eval;
  logic        f1_valid_q;

  assign cell_col  = s_axis_tdata[4:0];
  assign cell_row  = s_axis_tdata[9:5];
  assign grad_word = s_axis_tdata[41:10];
  assign off_col   = s_axis_tdata[48:42];
  assign off_row   = s_axis_tdata[55:49];

  // room must cover the beat already in the read stage
  assign s_axis_tready = (32'(q_status_i.count) + 32'(f1_valid_q)) < Q_DEPTH;
  assign beat    = s_axis_tvalid & s_axis_tready;
  assign is_load = beat && (op_e'(s_axis_tuser) == OP_LOAD) &&
                   (32'(cell_col) <= CELLS_ACROSS) && (32'(cell_row) <= CELLS_DOWN);
  assign is_eval = beat && (op_e'(s_axis_tuser) == OP_EVAL) &&
                   (32'(cell_col) < CELLS_ACROSS) && (32'(cell_row) < CELLS_DOWN);

  // fraction and fade per offset, worked out at elaboration; offsets past the cell clamp
  logic [FRAC_W-1:0] frac_lut [128];
  logic [FRAC_W-1:0] fade_lut [128];

  for (genvar i = 0; i < 128; i++) begin : g_lut
    localparam longint OI = (i < PIXELS_PER_CELL) ? i : PIXELS_PER_CELL - 1;
    localparam longint FV = (OI * 65536 + PIXELS_PER_CELL / 2) / PIXELS_PER_CELL;
    localparam longint T3 = (FV * FV * FV) / 65536;
    localparam longint IN = 10 * 65536 + (FV * (6 * FV - 15 * 65536)) / 65536;
    localparam longint RV = (T3 * IN + 64'sd2147483648) / 64'sd4294967296;
    localparam longint RC = (RV > 65536) ? 65536 : ((RV < 0) ? 0 : RV);
    assign frac_lut[i] = FRAC_W'(FV);
    assign fade_lut[i] = FRAC_W'(RC);
  end

  // four banks by corner row/column parity: a cell's corners hit each bank once
  logic [5:0]        col_p1, row_p1;
  logic [3:0][AW-1:0] rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [1:0]        wr_bank;

  assign col_p1  = 6'(cell_col) + 6'd1;
  assign row_p1  = 6'(cell_row) + 6'd1;
  assign wr_bank = {cell_row[0], cell_col[0]};
  assign wr_addr = AW'(32'(cell_row[4:1]) * BANK_COLS + 32'(cell_col[4:1]));

  always_comb begin
    logic [5:0] r, c;
    for (int b = 0; b < 4; b++) begin
      r = (cell_row[0] == b[1]) ? 6'(cell_row) : row_p1;
      c = (cell_col[0] == b[0]) ? 6'(cell_col) : col_p1;
      rd_addr[b] = AW'(32'(r[5:1]) * BANK_COLS + 32'(c[5:1]));
    end
  end

  logic [3:0][GRAD_W-1:0] rdata;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [GRAD_W-1:0] mem [BANK_DEPTH];
    logic [GRAD_W-1:0] rdata_q;
    always_ff @(posedge clk_i) begin
      if (is_load && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= grad_word;
      end
      if (is_eval) begin
        rdata_q <= mem[rd_addr[b]];
      end
    end
    assign rdata[b] = rdata_q;
  end

  logic              r0_q, c0_q;
  logic [FRAC_W-1:0] fx_q, fy_q, sx_q, sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= is_eval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_eval) begin
      r0_q <= cell_row[0];
      c0_q <= cell_col[0];
      fx_q <= frac_lut[off_col];
      fy_q <= frac_lut[off_row];
      sx_q <= fade_lut[off_col];
      sy_q <= fade_lut[off_row];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      q_item_o.grad[k] = rdata[{r0_q ^ k[1], c0_q ^ k[0]}];
    end
    q_item_o.fx = fx_q;
    q_item_o.fy = fy_q;
    q_item_o.sx = sx_q;
    q_item_o.sy = sy_q;
  end

  assign q_push_o = f1_valid_q;

endmodule

// ===== hdl/gnpe_queue.sv =====
`timescale 1ns / 1ps
module gnpe_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gnpe_pkg::item_t     push_item_i,
  input  logic                pop_i,
  output gnpe_pkg::item_t     pop_item_o,
  output gnpe_pkg::q_status_t status_o
);
  import gnpe_pkg::*;

  item_t              slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign pop_item_o         = slot_q[rd_ptr_q];
  assign status_o.count     = count_q;
  assign status_o.not_empty = (count_q != '0);

endmodule

// ===== hdl/gnpe_back.sv =====
`timescale 1ns / 1ps
module gnpe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gnpe_pkg::q_status_t q_status_i,
  input  gnpe_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata   // intensity
);
  import gnpe_pkg::*;

  logic advance;
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign q_pop_o = advance && q_status_i.not_empty;

  logic b1_valid_q, b2_valid_q, b3_valid_q;
  logic signed [DOT_W-1:0] dot_q [4];
  logic [FRAC_W-1:0]       sx_q, sy1_q, sy2_q;
  logic signed [DOT_W-1:0] bot_q, top_q, v_q;

  logic signed [17:0] dx0, dx1, dy0, dy1;
  assign dx0 = $signed({1'b0, q_item_i.fx});
  assign dy0 = $signed({1'b0, q_item_i.fy});
  assign dx1 = dx0 - 18'sd65536;
  assign dy1 = dy0 - 18'sd65536;

  // display mapping: trunc((v + 2^30) * 255 / 2^31), then 2d - 128, saturated
  logic signed [DISP_W-1:0] m_val, d_val, e_val;
  logic [7:0]               pix;
  always_comb begin
    m_val = (DISP_W'(v_q) + DISP_W'(64'sd1073741824)) * DISP_W'(255);
    if (m_val < 0) begin
      d_val = (m_val + DISP_W'(64'sd2147483647)) >>> 31;
    end else begin
      d_val = m_val >>> 31;
    end
    e_val = (d_val <<< 1) - DISP_W'(128);
    if (e_val < 0) begin
      pix = 8'd0;
    end else if (e_val > DISP_W'(255)) begin
      pix = 8'd255;
    end else begin
      pix = e_val[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q    <= 1'b0;
      b2_valid_q    <= 1'b0;
      b3_valid_q    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      b1_valid_q    <= q_status_i.not_empty;
      b2_valid_q    <= b1_valid_q;
      b3_valid_q    <= b2_valid_q;
      m_axis_tvalid <= b3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dot_q[0]     <= corner_dot(q_item_i.grad[0], dx0, dy0);
      dot_q[1]     <= corner_dot(q_item_i.grad[1], dx1, dy0);
      dot_q[2]     <= corner_dot(q_item_i.grad[2], dx0, dy1);
      dot_q[3]     <= corner_dot(q_item_i.grad[3], dx1, dy1);
      sx_q         <= q_item_i.sx;
      sy1_q        <= q_item_i.sy;
      bot_q        <= lerp(dot_q[0], dot_q[1], sx_q);
      top_q        <= lerp(dot_q[2], dot_q[3], sx_q);
      sy2_q        <= sy1_q;
      v_q          <= lerp(bot_q, top_q, sy2_q);
      m_axis_tdata <= pix;
    end
  end

endmodule

// ===== hdl/gradient_noise_pixel_engine.sv =====
`timescale 1ns / 1ps
// 2-D gradient noise, one pixel per beat. Opcode on tuser: a load beat writes the gradient of
// one lattice corner, an evaluate beat returns one 8-bit intensity. Loads and out-of-lattice
// beats give no result. Corner gradients live in four banks split by row/column parity, so
// the four corners of a cell are read together; fraction and fade come from constant
// tables. The front reads the banks and feeds a four-entry queue; the back does dot
// products, two blend stages and the display mapping. One beat per cycle is accepted while
// the queue has room; the back pipeline stalls while the output is not taken.
module gradient_noise_pixel_engine #(
  parameter int unsigned CELLS_ACROSS    = 16,
  parameter int unsigned CELLS_DOWN      = 16,
  parameter int unsigned PIXELS_PER_CELL = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // cell_col, cell_row, grad_x, grad_y, offset_col, offset_row
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // intensity
);
  import gnpe_pkg::*;

  q_status_t q_status;
  item_t     push_item, pop_item;
  logic      q_push, q_pop;

  gnpe_front #(
    .CELLS_ACROSS   (CELLS_ACROSS),
    .CELLS_DOWN     (CELLS_DOWN),
    .PIXELS_PER_CELL(PIXELS_PER_CELL)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_status_i   (q_status),
    .q_push_o     (q_push),
    .q_item_o     (push_item)
  );

  gnpe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_item_i(push_item),
    .pop_i      (q_pop),
    .pop_item_o (pop_item),
    .status_o   (q_status)
  );

  gnpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .q_item_i     (pop_item),
    .q_pop_o      (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

// ===== tb/gradient_noise_pixel_engine_tb.sv =====
`timescale 1ns / 1ps
module gradient_noise_pixel_engine_tb;
  import gnpe_pkg::*;

  localparam int CELLS_ACROSS = 16;
  localparam int CELLS_DOWN   = 16;
  localparam int PIX_PER_CELL = 128;
  localparam int CORNERS_ROW  = CELLS_ACROSS + 1;
  localparam int CORNER_TOTAL = CORNERS_ROW * (CELLS_DOWN + 1);
  localparam longint ONE_Q16  = 65536;
  localparam longint ONE_Q30  = 64'd1 << 30;
  localparam longint TWO_P31  = 64'd1 << 31;
  localparam longint TWO_P32  = 64'd1 << 32;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;

  class intensity_scoreboard;
    logic [31:0] corner_grad [CORNER_TOTAL];
    logic [7:0]  expected_intensity [$];
    int          fail_count = 0;

    function automatic longint pixel_fraction(logic [6:0] offset);
      longint o;
      o = offset;
      if (o >= PIX_PER_CELL) o = PIX_PER_CELL - 1;
      return (o * ONE_Q16 + PIX_PER_CELL / 2) / PIX_PER_CELL;
    endfunction

    function automatic longint quintic_fade(longint f);
      longint t3, inner, r;
      t3    = (f * f * f) / ONE_Q16;
      inner = 10 * ONE_Q16 + (f * (6 * f - 15 * ONE_Q16)) / ONE_Q16;
      r     = (t3 * inner + TWO_P31) / TWO_P32;
      if (r > ONE_Q16) r = ONE_Q16;
      if (r < 0) r = 0;
      return r;
    endfunction

    function automatic longint grad_dot(logic [31:0] w, longint dx, longint dy);
      longint gx, gy;
      gx = longint'($signed(w[15:0]));
      gy = longint'($signed(w[31:16]));
      return gx * dx + gy * dy;
    endfunction

    function automatic longint mix(longint a, longint b, longint s);
      return a + ((b - a) * s) / ONE_Q16;
    endfunction

    function automatic logic [7:0] predict_intensity(logic [4:0] col, logic [4:0] row,
                                                     logic [6:0] ocol, logic [6:0] orow);
      longint fx, fy, sx, sy, bot, top, v, d;
      int base;
      fx   = pixel_fraction(ocol);
      fy   = pixel_fraction(orow);
      sx   = quintic_fade(fx);
      sy   = quintic_fade(fy);
      base = row * CORNERS_ROW + col;
      bot  = mix(grad_dot(corner_grad[base], fx, fy),
                 grad_dot(corner_grad[base + 1], fx - ONE_Q16, fy), sx);
      top  = mix(grad_dot(corner_grad[base + CORNERS_ROW], fx, fy - ONE_Q16),
                 grad_dot(corner_grad[base + CORNERS_ROW + 1], fx - ONE_Q16, fy - ONE_Q16),
                 sx);
      v = mix(bot, top, sy);
      d = ((v + ONE_Q30) * 255) / TWO_P31;
      d = (d - 128) * 2 + 128;
      if (d < 0) d = 0;
      if (d > 255) d = 255;
      return d[7:0];
    endfunction

    function void note_beat(op_e op, logic [4:0] col, logic [4:0] row, logic [15:0] gx,
                            logic [15:0] gy, logic [6:0] ocol, logic [6:0] orow);
      if (op == OP_LOAD) begin
        if (col <= CELLS_ACROSS && row <= CELLS_DOWN)
          corner_grad[row * CORNERS_ROW + col] = {gy, gx};
      end else if (col < CELLS_ACROSS && row < CELLS_DOWN) begin
        expected_intensity.push_back(predict_intensity(col, row, ocol, orow));
      end
    endfunction

    function void check_pixel(logic [7:0] got);
      logic [7:0] want;
      if (expected_intensity.size() == 0) begin
        $error("intensity: no result expected, got %0d", got);
        fail_count++;
        return;
      end
      want = expected_intensity.pop_front();
      if (got !== want) begin
        $error("intensity: expected %0d, got %0d", want, got);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // cell_col, cell_row, grad_x, grad_y, offset_col, offset_row
  logic        s_axis_tuser = 1'b0; // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // intensity

  intensity_scoreboard sb = new();
  bit quiet_src, quiet_sink, hold_req;
  int idle_cycles;

  always #5 clk_i = ~clk_i;

  gradient_noise_pixel_engine i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // result checker and watchdog
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      wait_n = quiet_sink ? 0 : $urandom_range(0, 17);
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_beat(op_e op, logic [4:0] col, logic [4:0] row, logic [15:0] gx,
                           logic [15:0] gy, logic [6:0] ocol, logic [6:0] orow);
    int gap;
    gap = (quiet_src || hold_req) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {orow, ocol, gy, gx, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(op, col, row, gx, gy, ocol, orow);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_intensity.size() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_grad();
    case ($urandom_range(0, 5))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_eval();
    send_beat(OP_EVAL, 5'($urandom_range(0, CELLS_ACROSS - 1)),
              5'($urandom_range(0, CELLS_DOWN - 1)), 16'($urandom), 16'($urandom),
              7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every corner gets a gradient before any evaluate
    for (int r = 0; r <= CELLS_DOWN; r++)
      for (int c = 0; c <= CELLS_ACROSS; c++)
        send_beat(OP_LOAD, 5'(c), 5'(r), pick_grad(), pick_grad(), 7'($urandom), 7'($urandom));

    // corner cells, offset extremes, ignored beats outside the lattice
    send_beat(OP_EVAL, 5'd0, 5'd0, 16'h0, 16'h0, 7'd0, 7'd0);
    send_beat(OP_EVAL, 5'd0, 5'd0, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127);
    send_beat(OP_EVAL, 5'd15, 5'd15, 16'h0, 16'h0, 7'd127, 7'd0);
    send_beat(OP_EVAL, 5'd15, 5'd0, 16'h0, 16'h0, 7'd0, 7'd127);
    send_beat(OP_EVAL, 5'd7, 5'd9, 16'h0, 16'h0, 7'd64, 7'd64);
    send_beat(OP_EVAL, 5'd16, 5'd3, 16'h0, 16'h0, 7'd5, 7'd5);
    send_beat(OP_EVAL, 5'd3, 5'd16, 16'h0, 16'h0, 7'd5, 7'd5);
    send_beat(OP_EVAL, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127);
    send_beat(OP_LOAD, 5'd17, 5'd0, 16'h1234, 16'h5678, 7'd0, 7'd0);
    send_beat(OP_LOAD, 5'd0, 5'd17, 16'h1234, 16'h5678, 7'd0, 7'd0);
    send_beat(OP_LOAD, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127);
    send_beat(OP_LOAD, 5'd16, 5'd16, 16'h8000, 16'h7FFF, 7'd0, 7'd0);
    send_beat(OP_EVAL, 5'd15, 5'd15, 16'h0, 16'h0, 7'd100, 7'd30);
    send_beat(OP_LOAD, 5'd5, 5'd5, 16'h0, 16'h0, 7'd0, 7'd0);
    send_beat(OP_EVAL, 5'd5, 5'd5, 16'h0, 16'h0, 7'd0, 7'd0);
    send_beat(OP_EVAL, 5'd4, 5'd4, 16'h0, 16'h0, 7'd127, 7'd127);
    drain();

    // the sink holds off while beats keep coming, so the input backs up
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) random_eval();
    drain();

    for (int i = 0; i < 370; i++) begin
      if (i % 100 == 0) begin
        quiet_src  = ($urandom_range(0, 2) == 0);
        quiet_sink = ($urandom_range(0, 2) == 0);
      end
      case ($urandom_range(0, 9))
        0, 1: send_beat(OP_LOAD, 5'($urandom_range(0, CELLS_ACROSS)),
                        5'($urandom_range(0, CELLS_DOWN)), pick_grad(), pick_grad(),
                        7'($urandom), 7'($urandom));
        2: send_beat(op_e'($urandom_range(0, 1)), 5'($urandom), 5'($urandom),
                     16'($urandom), 16'($urandom), 7'($urandom), 7'($urandom));
        default: random_eval();
      endcase
      if (i == 185) drain();
    end
    drain();

    if (sb.fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
